[rtl/top_k_selection_by_value_defines.svh]
// assertion macros used by the top-k selection controller
`ifndef TOP_K_SELECTION_BY_VALUE_DEFINES_SVH
`define TOP_K_SELECTION_BY_VALUE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define TKSEL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// trigger in a cycle implies a condition in the next
`define TKSEL_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (expr)) \
    else $error(msg);

`endif

[rtl/tksel_pkg.sv]
// types and constants for the top-k selection block
`timescale 1ns / 1ps

package tksel_pkg;

  localparam int unsigned SelectW = 6;
  localparam logic [SelectW-1:0] SelectReset = 6'd5;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } tksel_state_e;

  typedef struct packed {
    logic insert;
    logic shift_out;
    logic clear;
  } tksel_cmd_t;

  typedef struct packed {
    logic empty;
    logic last_entry;
  } tksel_sts_t;

endpackage

[rtl/tksel_if.sv]
// valid/ready stream interfaces for candidates and picked ids
`timescale 1ns / 1ps

interface tksel_cand_if #(
  parameter int unsigned SCORE_BITS = 32,
  parameter int unsigned ID_BITS    = 24
);
  logic                  valid;
  logic                  ready;
  logic [SCORE_BITS-1:0] score;
  logic [ID_BITS-1:0]    node_id;
  logic                  set_end;

  modport source (output valid, output score, output node_id, output set_end, input ready);
  modport sink   (input valid, input score, input node_id, input set_end, output ready);
endinterface

interface tksel_pick_if #(
  parameter int unsigned ID_BITS = 24
);
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] chosen_id;
  logic               final_pick;

  modport source (output valid, output chosen_id, output final_pick, input ready);
  modport sink   (input valid, input chosen_id, input final_pick, output ready);
endinterface

[rtl/tksel_dpath.sv]
// sorted top-k list: compare-and-shift insertion cells and shift-out
`timescale 1ns / 1ps

module tksel_dpath import tksel_pkg::*; #(
  parameter int unsigned MAX_SELECT = 32,
  parameter int unsigned SCORE_BITS = 32,
  parameter int unsigned ID_BITS    = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tksel_cmd_t            cmd_i,
  output tksel_sts_t            sts_o,
  input  logic [SCORE_BITS-1:0] score_i,
  input  logic [ID_BITS-1:0]    node_id_i,
  output logic [ID_BITS-1:0]    chosen_id_o
);

  localparam int unsigned CW = $clog2(MAX_SELECT + 1);

  logic [SCORE_BITS-1:0] score_q [MAX_SELECT];
  logic [ID_BITS-1:0]    id_q    [MAX_SELECT];
  logic [MAX_SELECT-1:0] ge;
  logic [CW-1:0]         count_d, count_q;

  for (genvar g = 0; g < MAX_SELECT; g++) begin : g_cell
    logic                  prev_ge;
    logic                  take_new;
    logic                  take_left;
    logic [SCORE_BITS-1:0] left_score;
    logic [ID_BITS-1:0]    left_id;
    logic [ID_BITS-1:0]    right_id;

    if (g == 0) begin : g_head
      assign prev_ge    = 1'b1;
      assign left_score = score_q[g];
      assign left_id    = id_q[g];
    end else begin : g_body
      assign prev_ge    = ge[g-1];
      assign left_score = score_q[g-1];
      assign left_id    = id_q[g-1];
    end

    if (g == MAX_SELECT - 1) begin : g_tail
      assign right_id = id_q[g];
    end else begin : g_mid
      assign right_id = id_q[g+1];
    end

    // entry ranks at or above the candidate: ties keep the earlier arrival
    assign ge[g]     = (CW'(g) < count_q) && (score_q[g] >= score_i);
    assign take_new  = prev_ge && !ge[g];
    assign take_left = !prev_ge;

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert) begin
        if (take_new) begin
          score_q[g] <= score_i;
          id_q[g]    <= node_id_i;
        end else if (take_left) begin
          score_q[g] <= left_score;
          id_q[g]    <= left_id;
        end
      end else if (cmd_i.shift_out) begin
        id_q[g] <= right_id;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.insert) begin
      if (count_q != CW'(MAX_SELECT)) begin
        count_d = count_q + CW'(1);
      end
    end else if (cmd_i.shift_out) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign sts_o.empty      = (count_q == '0);
  assign sts_o.last_entry = (count_q == CW'(1));
  assign chosen_id_o      = id_q[0];

endmodule

[rtl/tksel_ctrl.sv]
// controller: select count register, insert and emit sequencing
`timescale 1ns / 1ps

`include "top_k_selection_by_value_defines.svh"

module tksel_ctrl import tksel_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SelectW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               final_pick_o,
  output tksel_cmd_t         cmd_o,
  input  tksel_sts_t         sts_i
);

  tksel_state_e       state_d, state_q;
  logic [SelectW-1:0] k_q;
  logic [SelectW-1:0] kleft_d, kleft_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= SelectReset;
      kleft_q <= '0;
    end else begin
      state_q <= state_d;
      kleft_q <= kleft_d;
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    kleft_d      = kleft_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    final_pick_o = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.insert = 1'b1;
          if (in_last_i) begin
            state_d = ST_EMIT;
            kleft_d = k_q;
          end
        end
      end
      ST_EMIT: begin
        if (kleft_q == '0 || sts_i.empty) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          out_valid_o  = 1'b1;
          final_pick_o = (kleft_q == SelectW'(1)) || sts_i.last_entry;
          if (out_ready_i) begin
            if (final_pick_o) begin
              cmd_o.clear = 1'b1;
              state_d     = ST_IDLE;
            end else begin
              cmd_o.shift_out = 1'b1;
              kleft_d         = kleft_q - SelectW'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `TKSEL_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "input taken during emit")
  `TKSEL_ASSERT_NEXT(a_final_frees, out_valid_o && out_ready_i && final_pick_o, in_ready_o, "not idle after final beat")
  `TKSEL_ASSERT_NEXT(a_mid_set_ready, in_valid_i && in_ready_o && !in_last_i, in_ready_o, "stalled inside a set")
  `TKSEL_ASSERT(a_cmd_excl, !(cmd_o.insert && (cmd_o.clear || cmd_o.shift_out)), "conflicting list commands")

endmodule

[rtl/top_k_selection_by_value.sv]
// top-k selection: keeps the best candidates of a set and reports their ids
//
// candidates arrive on cand_i (score, node_id, set_end); picks leave on pick_o
// (chosen_id, final_pick), both valid/ready, a beat moving when both are high.
// select_count is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while the block is idle, the block does not enforce this. each candidate is
// inserted into a sorted list of MAX_SELECT entries in the cycle it is taken, so
// candidates within a set stream at one beat per cycle. after the set_end beat,
// ready drops; the first pick is valid in the cycle right after that edge and picks
// follow one per cycle unless stalled, best first, ties in arrival order. the input
// stays closed until the set's picks end; the list shifts out through its head cell.
// when the receiver stalls, the current pick holds and the list does not move.
// the beat with final_pick clears the list and ready returns the next cycle.
// reset empties the list and sets select_count to 5; no clearing pass is needed.
`timescale 1ns / 1ps

module top_k_selection_by_value import tksel_pkg::*; #(
  parameter int unsigned MAX_SELECT = 32,
  parameter int unsigned SCORE_BITS = 32,
  parameter int unsigned ID_BITS    = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SelectW-1:0] cfg_wdata_i,
  tksel_cand_if.sink         cand_i,
  tksel_pick_if.source       pick_o
);

  tksel_cmd_t            cmd;
  tksel_sts_t            sts;
  logic [ID_BITS-1:0]    chosen_id;
  logic [SCORE_BITS-1:0] score;
  logic [ID_BITS-1:0]    node_id;

  assign score   = SCORE_BITS'(cand_i.score);
  assign node_id = ID_BITS'(cand_i.node_id);

  tksel_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (cand_i.valid),
    .in_last_i    (cand_i.set_end),
    .in_ready_o   (cand_i.ready),
    .out_valid_o  (pick_o.valid),
    .out_ready_i  (pick_o.ready),
    .final_pick_o (pick_o.final_pick),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  tksel_dpath #(
    .MAX_SELECT (MAX_SELECT),
    .SCORE_BITS (SCORE_BITS),
    .ID_BITS    (ID_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .score_i     (score),
    .node_id_i   (node_id),
    .chosen_id_o (chosen_id)
  );

  assign pick_o.chosen_id = chosen_id;

endmodule
